// File: design/rbt_pkg.sv
// Shared types, widths and register codes for the retry backoff table.
package rbt_pkg;

	localparam int TASK_W          = 6;
	localparam int TASK_SLOTS_DEF  = 64;
	localparam int CNT_W           = 8;
	localparam int DELAY_W         = 24;
	localparam int SCALED_W        = 32;
	localparam int MULT_W          = 16;
	localparam int PADDR_W         = 4;
	localparam int PDATA_W         = 32;

	// Transaction kinds on the request channel
	typedef enum logic [1:0] {
		KIND_QUERY  = 2'd0,
		KIND_RECORD = 2'd1,
		KIND_RESET  = 2'd2,
		KIND_CLEAR  = 2'd3
	} kind_t;

	// Register index (byte address / 4)
	typedef enum logic [1:0] {
		REG_MAX_RETRIES = 2'd0,
		REG_BASE_DELAY  = 2'd1,
		REG_MULTIPLIER  = 2'd2,
		REG_MAX_DELAY   = 2'd3
	} reg_idx_t;

	localparam logic [CNT_W-1:0]   MAX_RETRIES_RST = 8'd3;
	localparam logic [DELAY_W-1:0] BASE_DELAY_RST  = 24'd1000;
	localparam logic [MULT_W-1:0]  MULTIPLIER_RST  = 16'd512;
	localparam logic [DELAY_W-1:0] MAX_DELAY_RST   = 24'd30000;

	// Configuration as seen by the engine
	typedef struct packed {
		logic [CNT_W-1:0]   max_retries;
		logic [DELAY_W-1:0] base_delay_ms;
		logic [MULT_W-1:0]  backoff_multiplier_q8;
		logic [DELAY_W-1:0] max_delay_ms;
	} cfg_t;

	// One table entry
	typedef struct packed {
		logic [CNT_W-1:0]    attempts;
		logic [SCALED_W-1:0] scaled;
		logic [DELAY_W-1:0]  delay;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	// Engine sequencer
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CALC
	} state_t;

endpackage

// File: design/rbt_ifs.sv
// Request and response channel interfaces.
interface rbt_req_if import rbt_pkg::*; ();
	logic              valid;
	logic              ready;
	kind_t             kind;
	logic [TASK_W-1:0] task_index;

	modport source (output valid, kind, task_index, input ready);
	modport sink   (input valid, kind, task_index, output ready);
endinterface

interface rbt_rsp_if import rbt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               can_retry;
	logic [CNT_W-1:0]   attempt_count;
	logic [DELAY_W-1:0] next_delay_ms;
	logic               retry_scheduled;
	logic               retries_exhausted;

	modport source (output valid, can_retry, attempt_count, next_delay_ms,
		retry_scheduled, retries_exhausted, input ready);
	modport sink   (input valid, can_retry, attempt_count, next_delay_ms,
		retry_scheduled, retries_exhausted, output ready);
endinterface

// File: design/rbt_ram.sv
// Generic single-port-write, registered-read RAM.
module rbt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/rbt_cfg.sv
// APB configuration registers.
module rbt_cfg import rbt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr     = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_retries           <= MAX_RETRIES_RST;
			cfg_q.base_delay_ms         <= BASE_DELAY_RST;
			cfg_q.backoff_multiplier_q8 <= MULTIPLIER_RST;
			cfg_q.max_delay_ms          <= MAX_DELAY_RST;
		end else if (wr) begin
			case (idx)
				REG_MAX_RETRIES: cfg_q.max_retries           <= pwdata[CNT_W-1:0];
				REG_BASE_DELAY:  cfg_q.base_delay_ms         <= pwdata[DELAY_W-1:0];
				REG_MULTIPLIER:  cfg_q.backoff_multiplier_q8 <= pwdata[MULT_W-1:0];
				REG_MAX_DELAY:   cfg_q.max_delay_ms          <= pwdata[DELAY_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		case (idx)
			REG_MAX_RETRIES: prdata = PDATA_W'(cfg_q.max_retries);
			REG_BASE_DELAY:  prdata = PDATA_W'(cfg_q.base_delay_ms);
			REG_MULTIPLIER:  prdata = PDATA_W'(cfg_q.backoff_multiplier_q8);
			REG_MAX_DELAY:   prdata = PDATA_W'(cfg_q.max_delay_ms);
			default:         prdata = '0;
		endcase
	end

endmodule

// File: design/rbt_core.sv
// Slot table engine: read, multiply, update and write back one entry per transaction.
module rbt_core import rbt_pkg::*; #(
	parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	rbt_req_if.sink   req,
	rbt_rsp_if.source rsp
);

	// only slots reachable by a task index are stored
	localparam int USED = (TASK_SLOTS < (1 << TASK_W)) ? TASK_SLOTS : (1 << TASK_W);
	localparam int AW   = $clog2(USED);

	state_t state_q, state_d;

	logic [USED-1:0] valid_q;

	kind_t   kind_s1;
	logic    inr_s1;
	logic [AW-1:0] addr_s1;

	slot_t                      rd_data;
	slot_t                      ent_s2;
	logic [SCALED_W+MULT_W-1:0] prod_s2;

	logic accept, fire, ram_we;
	logic in_range;
	logic [AW-1:0] in_addr;

	// output register
	logic               out_valid_q;
	logic               can_retry_q, sched_q, exh_q;
	logic [CNT_W-1:0]   count_q;
	logic [DELAY_W-1:0] delay_q;

	// update datapath
	logic                 vld;
	logic [CNT_W-1:0]     old_cnt, new_cnt;
	logic                 cnt_full;
	logic [SCALED_W+MULT_W-9:0] shifted;
	logic [SCALED_W-1:0]  grown, new_scaled;
	logic [DELAY_W-1:0]   new_delay;
	slot_t                wr_data;
	logic                 is_record;
	logic                 r_can, r_sched, r_exh;
	logic [CNT_W-1:0]     r_count;
	logic [DELAY_W-1:0]   r_delay;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign in_range  = 32'(req.task_index) < 32'(USED);
	assign in_addr   = AW'(req.task_index);
	assign fire      = (state_q == ST_CALC) && (!out_valid_q || rsp.ready);

	rbt_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (USED)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_s1),
		.wdata (wr_data),
		.re    (accept),
		.raddr (in_addr),
		.rdata (rd_data)
	);

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept) state_d = ST_READ;
			ST_READ: state_d = ST_CALC;
			ST_CALC: if (fire) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// transaction capture
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= req.kind;
			inr_s1  <= in_range;
			addr_s1 <= in_addr;
		end
	end

	// entry and product, registered from the read data in ST_READ
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			ent_s2  <= rd_data;
			prod_s2 <= rd_data.scaled * cfg.backoff_multiplier_q8;
		end
	end

	// new entry values for a record
	always_comb begin
		vld        = valid_q[addr_s1] && inr_s1;
		old_cnt    = vld ? ent_s2.attempts : '0;
		cnt_full   = (old_cnt == '1);
		new_cnt    = cnt_full ? old_cnt : old_cnt + 1'b1;
		shifted    = prod_s2[SCALED_W+MULT_W-1:8];
		grown      = (|shifted[SCALED_W+MULT_W-9:SCALED_W]) ? '1 : shifted[SCALED_W-1:0];
		new_scaled = cnt_full ? ent_s2.scaled
			: ((old_cnt == '0) ? SCALED_W'(cfg.base_delay_ms) : grown);
		new_delay  = cnt_full ? ent_s2.delay
			: ((new_scaled < SCALED_W'(cfg.max_delay_ms)) ? new_scaled[DELAY_W-1:0]
				: cfg.max_delay_ms);
		wr_data.attempts = new_cnt;
		wr_data.scaled   = new_scaled;
		wr_data.delay    = new_delay;
		is_record        = (kind_s1 == KIND_RECORD) && inr_s1;
		ram_we           = fire && is_record;
	end

	// result fields
	always_comb begin
		r_sched = 1'b0;
		r_exh   = 1'b0;
		r_can   = 1'b1;
		r_count = '0;
		r_delay = cfg.base_delay_ms;
		case (kind_s1)
			KIND_RECORD: begin
				if (inr_s1) begin
					r_can   = new_cnt < cfg.max_retries;
					r_sched = r_can;
					r_exh   = !r_can;
					r_count = new_cnt;
					r_delay = new_delay;
				end
			end
			KIND_QUERY: begin
				if (vld) begin
					r_can   = ent_s2.attempts < cfg.max_retries;
					r_count = ent_s2.attempts;
					r_delay = ent_s2.delay;
				end
			end
			default: ;
		endcase
	end

	// valid marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (fire) begin
			if (kind_s1 == KIND_CLEAR) begin
				valid_q <= '0;
			end else if (inr_s1 && kind_s1 == KIND_RESET) begin
				valid_q[addr_s1] <= 1'b0;
			end else if (is_record) begin
				valid_q[addr_s1] <= 1'b1;
			end
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			can_retry_q <= r_can;
			count_q     <= r_count;
			delay_q     <= r_delay;
			sched_q     <= r_sched;
			exh_q       <= r_exh;
		end
	end

	assign rsp.valid             = out_valid_q;
	assign rsp.can_retry         = can_retry_q;
	assign rsp.attempt_count     = count_q;
	assign rsp.next_delay_ms     = delay_q;
	assign rsp.retry_scheduled   = sched_q;
	assign rsp.retries_exhausted = exh_q;

endmodule

// File: design/retry_backoff_table.sv
// Top level of the retry backoff table.
//
//  channel | dir | handshake      | payload
//  --------+-----+----------------+--------------------------------------------
//  req     | in  | valid/ready    | kind, task_index
//  rsp     | out | valid/ready    | can_retry, attempt_count, next_delay_ms,
//          |     |                | retry_scheduled, retries_exhausted
//  apb     | in  | psel/penable   | paddr, pwdata, prdata (pready tied high)
//
// Each transaction passes through a table read, a registered Q8.8 multiply, then
// an update with write-back; req.ready is high only while the engine is idle.
// Reset clears all valid marks at once; no clearing pass.
// A finished response waits in the output register; a new request is still
// taken, and the engine holds in its update stage until that register frees.
module retry_backoff_table import rbt_pkg::*; #(
	parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	rbt_req_if.sink            req,
	rbt_rsp_if.source          rsp
);

	cfg_t cfg;

	rbt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rbt_core #(
		.TASK_SLOTS (TASK_SLOTS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

// File: design/rbt_checker.sv
// Port-level checks for the retry backoff table, bound to the top level.
module rbt_checker import rbt_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic               can_retry,
	input logic [CNT_W-1:0]   attempt_count,
	input logic [DELAY_W-1:0] next_delay_ms,
	input logic               retry_scheduled,
	input logic               retries_exhausted
);

	// a held response keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(attempt_count)
			&& $stable(next_delay_ms) && $stable(can_retry))
		else $error("response changed while stalled");

	// one transaction at a time: ready drops after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while engine busy");

	// flags are exclusive
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(retry_scheduled && retries_exhausted))
		else $error("scheduled and exhausted both set");

	// a record response has a nonzero count and can_retry follows scheduled
	a_record_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (retry_scheduled || retries_exhausted)
			|-> attempt_count != '0 && can_retry == retry_scheduled)
		else $error("record response inconsistent");

	// an empty slot can always retry
	a_empty_retry: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && attempt_count == '0 |-> can_retry)
		else $error("zero count without can_retry");

endmodule

bind retry_backoff_table rbt_checker u_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.can_retry         (rsp.can_retry),
	.attempt_count     (rsp.attempt_count),
	.next_delay_ms     (rsp.next_delay_ms),
	.retry_scheduled   (rsp.retry_scheduled),
	.retries_exhausted (rsp.retries_exhausted)
);
